// File: src/mpms_pkg.sv
// ----------------------------------------------------------------------------
// mpms_pkg: shared types and constants
// Command codes, status codes and sequencer states for the scanner.
// ----------------------------------------------------------------------------
package mpms_pkg;

  localparam int unsigned MaxNodesDef    = 256;
  localparam int unsigned AlphabetDef    = 256;
  localparam int unsigned MaxPatternsDef = 64;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_END   = 2'd1,
    CMD_BUILD = 2'd2,
    CMD_SCAN  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NO_BUILD = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR,     // zeroing tables after reset
    S_IDLE,
    S_ADD,       // child read returned
    S_SCAN_RD,   // child read of walk node returned
    S_SCAN_FL,   // fail read returned
    S_SCAN_PAT,  // pattern read returned
    S_B_ROOT,    // issue root-child read for sym
    S_B_ROOTW,   // root-child data
    S_B_POP,     // pop queue entry
    S_B_POPW,    // queue data; issue fail read of cur
    S_B_CHILD,   // child(cur,sym) data
    S_B_WALK,    // child(walk,sym) data
    S_B_WFL,     // fail(walk) data
    S_B_PAT,     // own/node_pattern data
    S_OUT
  } state_e;

endpackage

// File: src/multi_pattern_match_scanner_unit.sv
// Throughput: one item at a time; the next input transfer can be taken in the
//   cycle after the result transfer.
// Reset: async; a pass over all 2**(node bits + symbol bits) entries (65536 by
//   default) zeroes child and pattern tables first; failure links and queue
//   undefined.
// ----------------------------------------------------------------------------
// multi_pattern_match_scanner_unit: Aho-Corasick matcher
// Trie, failure links and patterns live in synchronous memories; one
// sequencer handles load, build and scan items.
// ----------------------------------------------------------------------------
module multi_pattern_match_scanner_unit
  import mpms_pkg::*;
#(
  parameter int unsigned MAX_NODES     = MaxNodesDef,
  parameter int unsigned ALPHABET_SIZE = AlphabetDef,
  parameter int unsigned MAX_PATTERNS  = MaxPatternsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // command[1:0], symbol[9:2], text_start[10]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata   // match_found[0], match_id[6:1], status[8:7]
);

  localparam int unsigned NW   = (MAX_NODES > 2) ? $clog2(MAX_NODES) : 1;
  localparam int unsigned SW   = (ALPHABET_SIZE > 2) ? $clog2(ALPHABET_SIZE) : 1;
  localparam int unsigned PW   = $clog2(MAX_PATTERNS + 1);
  localparam int unsigned CW   = NW + SW;
  localparam int unsigned CD   = 2 ** CW;
  localparam int unsigned CNTW = NW + 1;

  // child table indexed by {node, symbol}; zero means no child
  logic [NW-1:0] child_mem [CD];
  logic [PW-1:0] own_mem   [MAX_NODES];
  logic [PW-1:0] pat_mem   [MAX_NODES];
  logic [NW-1:0] fail_mem  [MAX_NODES];
  logic [NW-1:0] que_mem   [MAX_NODES];

  state_e        state_q, state_d;
  logic [CNTW-1:0] node_cnt_q, node_cnt_d;
  logic [PW-1:0]   pat_cnt_q, pat_cnt_d;
  logic [NW-1:0]   ins_q, ins_d, scn_q, scn_d;
  logic            built_q, built_d;
  logic [SW-1:0]   sym_q, sym_d;
  logic [NW-1:0]   cur_q, cur_d, walk_q, walk_d, chd_q, chd_d;
  logic [CNTW-1:0] head_q, head_d, tail_q, tail_d;
  logic [SW:0]     bsym_q, bsym_d;
  logic [CNTW-1:0] guard_q, guard_d;
  logic            out_vld_q, out_vld_d;
  logic [8:0]      out_q, out_d;
  logic [CW-1:0]   clr_q, clr_d;

  // memory ports
  logic          c_re, c_we;
  logic [NW-1:0] c_node, cw_node;
  logic [SW-1:0] c_sym, cw_sym;
  logic [NW-1:0] c_wd;
  logic [NW-1:0] c_rd;
  logic          c_hit;
  logic [NW-1:0] c_rdq;

  logic          n_we, f_we, q_we, o_we;
  logic [NW-1:0] n_a, n_wa, f_a, f_wa, q_a, q_wa, o_wa;
  logic [PW-1:0] n_wd, o_wd, n_rd, o_rd;
  logic [NW-1:0] f_wd, q_wd, f_rd, q_rd;
  logic [PW-1:0] n_rdq, o_rdq;
  logic [NW-1:0] n_a_q;

  always_ff @(posedge clk_i) begin
    if (c_we) child_mem[{cw_node, cw_sym}] <= c_wd;
    if (c_re) c_rdq <= child_mem[{c_node, c_sym}];
    if (o_we) own_mem[o_wa] <= o_wd;
    if (n_we) pat_mem[n_wa] <= n_wd;
    if (f_we) fail_mem[f_wa] <= f_wd;
    if (q_we) que_mem[q_wa] <= q_wd;
    o_rdq <= own_mem[n_a];
    n_rdq <= pat_mem[n_a];
    f_rd  <= fail_mem[f_a];
    q_rd  <= que_mem[q_a];
  end

  assign c_rd  = c_rdq;
  assign o_rd  = o_rdq;
  assign n_rd  = n_rdq;
  assign c_hit = c_rd != '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_a_q <= '0;
    end else begin
      n_a_q <= n_a;
    end
  end

  logic [1:0]    in_cmd;
  logic [SW-1:0] in_sym;
  logic          in_ts;
  assign in_cmd = s_axis_tdata[1:0];
  assign in_sym = SW'(s_axis_tdata[9:2]);
  assign in_ts  = s_axis_tdata[10];

  assign s_axis_tready = (state_q == S_IDLE) && !out_vld_q;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {7'd0, out_q};

  function automatic logic [8:0] pack(input logic f, input logic [PW-1:0] id,
                                      input status_e st);
    logic [5:0] i6;
    i6 = 6'(id);
    pack = {st, i6, f};
  endfunction

  always_comb begin
    state_d = state_q; node_cnt_d = node_cnt_q; pat_cnt_d = pat_cnt_q;
    ins_d = ins_q; scn_d = scn_q; built_d = built_q;
    sym_d = sym_q; cur_d = cur_q; walk_d = walk_q; chd_d = chd_q;
    head_d = head_q; tail_d = tail_q; bsym_d = bsym_q; guard_d = guard_q;
    out_vld_d = out_vld_q; out_d = out_q; clr_d = clr_q;
    c_re = 1'b0; c_we = 1'b0; c_node = '0; c_sym = '0;
    cw_node = '0; cw_sym = '0; c_wd = '0;
    n_we = 1'b0; o_we = 1'b0; f_we = 1'b0; q_we = 1'b0;
    n_a = '0; n_wa = '0; n_wd = '0; o_wa = '0; o_wd = '0;
    f_a = '0; f_wa = '0; f_wd = '0; q_a = '0; q_wa = '0; q_wd = '0;
    if (out_vld_q && m_axis_tready) out_vld_d = 1'b0;
    unique case (state_q)
      // zero the child and pattern tables, one entry per cycle
      S_CLEAR: begin
        c_we = 1'b1; cw_node = clr_q[CW-1:SW]; cw_sym = clr_q[SW-1:0];
        if (clr_q < CW'(MAX_NODES)) begin
          o_we = 1'b1; o_wa = NW'(clr_q);
          n_we = 1'b1; n_wa = NW'(clr_q);
        end
        if (clr_q == CW'(CD - 1)) state_d = S_IDLE;
        else clr_d = clr_q + 1'b1;
      end
      S_IDLE: begin
        if (s_axis_tvalid && s_axis_tready) begin
          sym_d = in_sym;
          unique case (cmd_e'(in_cmd))
            CMD_ADD: begin
              c_re = 1'b1; c_node = ins_q; c_sym = in_sym; state_d = S_ADD;
            end
            CMD_END: begin
              out_d = pack(1'b0, '0, ST_OK);
              if (ins_q != '0) begin
                if (pat_cnt_q >= PW'(MAX_PATTERNS)) out_d = pack(1'b0, '0, ST_FULL);
                else begin
                  o_we = 1'b1; o_wa = ins_q; o_wd = pat_cnt_q + 1'b1;
                  pat_cnt_d = pat_cnt_q + 1'b1; built_d = 1'b0;
                end
              end
              ins_d = '0; out_vld_d = 1'b1;
            end
            CMD_BUILD: begin
              n_a = '0; bsym_d = '0; head_d = '0; tail_d = '0;
              f_we = 1'b1; f_wa = '0; f_wd = '0;
              state_d = S_B_ROOT;
            end
            default: begin
              walk_d = in_ts ? '0 : scn_q;
              scn_d = walk_d;
              if (!built_q) begin
                out_d = pack(1'b0, '0, ST_NO_BUILD); out_vld_d = 1'b1;
              end else begin
                c_re = 1'b1; c_node = walk_d; c_sym = in_sym;
                guard_d = '0; state_d = S_SCAN_RD;
              end
            end
          endcase
        end
      end
      S_ADD: begin
        out_d = pack(1'b0, '0, ST_OK);
        if (c_hit) ins_d = c_rd;
        else if (node_cnt_q >= CNTW'(MAX_NODES)) out_d = pack(1'b0, '0, ST_FULL);
        else begin
          c_we = 1'b1; cw_node = ins_q; cw_sym = sym_q; c_wd = NW'(node_cnt_q);
          o_we = 1'b1; o_wa = NW'(node_cnt_q); o_wd = '0;
          n_we = 1'b1; n_wa = NW'(node_cnt_q); n_wd = '0;
          ins_d = NW'(node_cnt_q); node_cnt_d = node_cnt_q + 1'b1; built_d = 1'b0;
        end
        out_vld_d = 1'b1; state_d = S_IDLE;
      end
      S_SCAN_RD: begin
        if (walk_q != '0 && !c_hit && guard_q < CNTW'(MAX_NODES)) begin
          f_a = walk_q; guard_d = guard_q + 1'b1; state_d = S_SCAN_FL;
        end else begin
          chd_d = c_rd; n_a = c_rd; state_d = S_SCAN_PAT;
        end
      end
      S_SCAN_FL: begin
        walk_d = f_rd; c_re = 1'b1; c_node = f_rd; c_sym = sym_q; state_d = S_SCAN_RD;
      end
      S_SCAN_PAT: begin
        n_a = chd_q;
        if (n_rd != '0) begin
          out_d = pack(1'b1, n_rd - 1'b1, ST_OK); scn_d = '0;
        end else begin
          out_d = pack(1'b0, '0, ST_OK); scn_d = chd_q;
        end
        out_vld_d = 1'b1; state_d = S_IDLE;
      end
      // root: node_pattern[0] = own[0]; then children of root
      S_B_ROOT: begin
        n_a = '0;
        if (bsym_q == '0) begin
          n_we = 1'b1; n_wa = '0; n_wd = o_rd;
        end
        if (bsym_q == (SW+1)'(ALPHABET_SIZE)) state_d = S_B_POP;
        else begin
          c_re = 1'b1; c_node = '0; c_sym = SW'(bsym_q); state_d = S_B_ROOTW;
        end
      end
      S_B_ROOTW: begin
        if (c_hit && tail_q < CNTW'(MAX_NODES)) begin
          f_we = 1'b1; f_wa = c_rd; f_wd = '0;
          q_we = 1'b1; q_wa = NW'(tail_q); q_wd = c_rd;
          tail_d = tail_q + 1'b1;
          cur_d = '0; chd_d = c_rd; walk_d = '0; n_a = c_rd;
          state_d = S_B_PAT;
        end else begin
          bsym_d = bsym_q + 1'b1; n_a = '0; state_d = S_B_ROOT;
        end
      end
      S_B_POP: begin
        if (head_q >= tail_q) begin
          built_d = 1'b1; out_d = pack(1'b0, '0, ST_OK); out_vld_d = 1'b1;
          state_d = S_IDLE;
        end else begin
          q_a = NW'(head_q); head_d = head_q + 1'b1; state_d = S_B_POPW;
        end
      end
      S_B_POPW: begin
        cur_d = q_rd; bsym_d = '0; f_a = q_rd;
        c_re = 1'b1; c_node = q_rd; c_sym = '0; state_d = S_B_CHILD;
      end
      S_B_CHILD: begin
        f_a = cur_q;
        if (bsym_q == (SW+1)'(ALPHABET_SIZE)) state_d = S_B_POP;
        else if (c_hit && tail_q < CNTW'(MAX_NODES)) begin
          chd_d = c_rd; walk_d = f_rd; guard_d = '0;
          c_re = 1'b1; c_node = f_rd; c_sym = SW'(bsym_q); state_d = S_B_WALK;
        end else begin
          bsym_d = bsym_q + 1'b1;
          if (bsym_q + 1'b1 != (SW+1)'(ALPHABET_SIZE)) begin
            c_re = 1'b1; c_node = cur_q; c_sym = SW'(bsym_q + 1'b1);
          end
        end
      end
      S_B_WALK: begin
        if (walk_q != '0 && !c_hit && guard_q < CNTW'(MAX_NODES)) begin
          f_a = walk_q; guard_d = guard_q + 1'b1; state_d = S_B_WFL;
        end else begin
          walk_d = c_rd; n_a = chd_q;
          f_we = 1'b1; f_wa = chd_q; f_wd = c_rd;
          q_we = 1'b1; q_wa = NW'(tail_q); q_wd = chd_q; tail_d = tail_q + 1'b1;
          state_d = S_B_PAT;
        end
      end
      S_B_WFL: begin
        walk_d = f_rd; c_re = 1'b1; c_node = f_rd; c_sym = SW'(bsym_q);
        state_d = S_B_WALK;
      end
      // two reads of pattern memories: own(child) then node_pattern(walk)
      S_B_PAT: begin
        if (guard_q != CNTW'(MAX_NODES + 1)) begin
          n_a = chd_q; chd_d = chd_q; guard_d = CNTW'(MAX_NODES + 1);
          state_d = S_B_PAT;
          if (n_a_q == chd_q) begin
            cur_d = cur_q;
            walk_d = walk_q;
            n_a = walk_q;
            o_wd = o_rd;
            // hold own in out_d lower bits temporarily
            out_d = 9'(o_rd);
            guard_d = CNTW'(MAX_NODES + 1);
          end else guard_d = '0;
        end else begin
          n_a = walk_q;
          n_we = 1'b1; n_wa = chd_q;
          n_wd = (PW'(out_q) != '0) ? PW'(out_q) : n_rd;
          guard_d = '0;
          bsym_d = bsym_q + 1'b1;
          if (cur_q == '0 && head_q == '0) begin
            state_d = S_B_ROOT;
          end else begin
            // fail(cur) must be ready again for the next child
            f_a = cur_q;
            if (bsym_q + 1'b1 != (SW+1)'(ALPHABET_SIZE)) begin
              c_re = 1'b1; c_node = cur_q; c_sym = SW'(bsym_q + 1'b1);
            end
            state_d = S_B_CHILD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR; node_cnt_q <= CNTW'(1); pat_cnt_q <= '0;
      ins_q <= '0; scn_q <= '0; built_q <= 1'b0; out_vld_q <= 1'b0;
      head_q <= '0; tail_q <= '0; bsym_q <= '0; guard_q <= '0;
      sym_q <= '0; cur_q <= '0; walk_q <= '0; chd_q <= '0;
      out_q <= '0; clr_q <= '0;
    end else begin
      state_q <= state_d; node_cnt_q <= node_cnt_d; pat_cnt_q <= pat_cnt_d;
      ins_q <= ins_d; scn_q <= scn_d; built_q <= built_d; out_vld_q <= out_vld_d;
      head_q <= head_d; tail_q <= tail_d; bsym_q <= bsym_d; guard_q <= guard_d;
      sym_q <= sym_d; cur_q <= cur_d; walk_q <= walk_d;
      chd_q <= chd_d; out_q <= out_d; clr_q <= clr_d;
    end
  end

endmodule

// File: src/mpms_checker.sv
// ----------------------------------------------------------------------------
// mpms_checker: port-level checks for the scanner
// Watches the stream ports of the top level.
// ----------------------------------------------------------------------------
module mpms_checker
  import mpms_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped while stalled");

  a_no_id_without_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[6:1] == 6'd0)
    else $error("id without match");

  a_match_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[8:7] == ST_OK)
    else $error("match with bad status");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input taken with result pending");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[8:7] != 2'd3)
    else $error("bad status code");

endmodule

bind multi_pattern_match_scanner_unit mpms_checker u_mpms_checker (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);
